// File: rtl/core/hep_pkg.sv
// Shared constants, types and a saturation helper for the Heston path step engine.
package hep_pkg;

    // Fixed-point formats.
    localparam int DEFAULT_FRACTION_BITS = 24;
    localparam int NORMAL_FRACTION       = 12;
    localparam int WORD_W                = 32;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DRIFT_RATE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSION_SPEED   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_RUN_VARIANCE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VOL_OF_VOL        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CORRELATION       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP         = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_START_LOG_PRICE   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_START_VARIANCE    = 3'd7;

    // Register reset values, Q8.24 codes.
    localparam logic [31:0] RST_DRIFT_RATE        = 32'd838861;
    localparam logic [30:0] RST_REVERSION_SPEED   = 31'd33554432;
    localparam logic [30:0] RST_LONG_RUN_VARIANCE = 31'd671089;
    localparam logic [30:0] RST_VOL_OF_VOL        = 31'd5033165;
    localparam logic [25:0] RST_CORRELATION       = 26'h380_0000;
    localparam logic [24:0] RST_TIME_STEP         = 25'd335544;
    localparam logic [31:0] RST_START_LOG_PRICE   = 32'd0;
    localparam logic [30:0] RST_START_VARIANCE    = 31'd671089;

    // Request to the serial multiplier: a * b, shifted by the long or short fraction.
    typedef struct packed {
        logic               start;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic               long_shift;
    } t_mul_req;

    // Request to the serial square root.
    typedef struct packed {
        logic        start;
        logic [30:0] radicand;
    } t_sqrt_req;

    // Response from either arithmetic unit.
    typedef struct packed {
        logic               done;
        logic signed [31:0] value;
    } t_unit_rsp;

    // Saturate a 33-bit signed sum to the signed 32-bit range.
    function automatic logic signed [31:0] sat33(input logic signed [32:0] x);
        logic signed [31:0] res;
        if (x[32] != x[31]) begin
            res = x[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            res = x[31:0];
        end
        return res;
    endfunction

endpackage

// File: rtl/core/hep_in_if.sv
// Input channel carrying one pair of normal draws and the path flags per word.
interface hep_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] normal_a;
    logic signed [15:0] normal_b;
    logic               first_step;
    logic               last_step;

    modport source (output valid, output normal_a, output normal_b,
                    output first_step, output last_step, input ready);
    modport sink   (input valid, input normal_a, input normal_b,
                    input first_step, input last_step, output ready);
endinterface

// File: rtl/core/hep_out_if.sv
// Output channel carrying the terminal log price and variance of one path.
interface hep_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] terminal_log_price;
    logic        [30:0] terminal_variance;

    modport source (output valid, output terminal_log_price, output terminal_variance,
                    input ready);
    modport sink   (input valid, input terminal_log_price, input terminal_variance,
                    output ready);
endinterface

// File: rtl/core/heston_euler_path_step.sv
// Heston path engine: one Euler step of log price and variance per input word, serial datapath.
//
// Each accepted word runs one Euler step of the Heston dynamics in signed Q8.24 (with
// FRACTION_BITS = 24) through a sequencer that shares one bit-serial 32x32 multiplier and
// one bit-serial square root. The units work one at a time, so a plain step takes 10
// multiplies and one root of the variance, and a word that emits a result also passes
// through the emit state. A word with first_step set first loads the start values and
// works out sqrt(dt) and sqrt(1 - rho^2), which adds one multiply and two roots. The
// input takes a new word only when the previous step is finished. A word with last_step
// set leaves one result in an output register, where it may wait while the next path
// starts; a second result stalls the sequencer only if the first has not yet been taken.
// Configuration writes are taken in any cycle and act at once, so they belong between
// steps; the start values and both roots are read only when a path starts.
module heston_euler_path_step #(
    parameter int FRACTION_BITS = hep_pkg::DEFAULT_FRACTION_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [hep_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [hep_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    hep_in_if.sink                           i_item,
    hep_out_if.source                        o_result
);
    import hep_pkg::*;

    // Sequencer states: idle, one per arithmetic operation, and emit.
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RS   = 4'd1;
    localparam logic [3:0] S_RHO2 = 4'd2;
    localparam logic [3:0] S_DF   = 4'd3;
    localparam logic [3:0] S_DWS  = 4'd4;
    localparam logic [3:0] S_M1   = 4'd5;
    localparam logic [3:0] S_M2   = 4'd6;
    localparam logic [3:0] S_DWV  = 4'd7;
    localparam logic [3:0] S_SV   = 4'd8;
    localparam logic [3:0] S_T1   = 4'd9;
    localparam logic [3:0] S_T2   = 4'd10;
    localparam logic [3:0] S_A    = 4'd11;
    localparam logic [3:0] S_B    = 4'd12;
    localparam logic [3:0] S_C    = 4'd13;
    localparam logic [3:0] S_E    = 4'd14;
    localparam logic [3:0] S_EMIT = 4'd15;

    // Configuration registers.
    logic signed [31:0] r_drift_rate;
    logic        [30:0] r_reversion_speed;
    logic        [30:0] r_long_run_variance;
    logic        [30:0] r_vol_of_vol;
    logic signed [25:0] r_correlation;
    logic        [24:0] r_time_step;
    logic signed [31:0] r_start_log_price;
    logic        [30:0] r_start_variance;

    // Path state and intermediates.
    logic signed [31:0] r_lp;
    logic        [30:0] r_v;
    logic signed [31:0] r_rs;
    logic signed [31:0] r_df;
    logic signed [31:0] r_dws;
    logic signed [31:0] r_mix;
    logic signed [31:0] r_dwv;
    logic signed [31:0] r_sv;
    logic signed [31:0] r_t;
    logic signed [31:0] r_a;
    logic signed [15:0] r_z1;
    logic signed [15:0] r_z2;
    logic               r_last;

    // Control.
    logic [3:0]         r_state;
    logic [3:0]         n_state;
    logic               r_busy;
    logic               r_out_valid;
    logic signed [31:0] r_out_lp;
    logic        [30:0] r_out_v;

    t_mul_req           mul_req;
    t_sqrt_req          sq_req;
    t_unit_rsp          mul_rsp;
    t_unit_rsp          sq_rsp;

    logic               accept;
    logic               is_mul_state;
    logic               is_sq_state;
    logic               unit_done;
    logic               emit_load;
    logic signed [31:0] z1_ext;
    logic signed [31:0] z2_ext;
    logic signed [31:0] rho_ext;
    logic signed [31:0] dt_ext;
    logic signed [31:0] drift;
    logic signed [31:0] rev;
    logic signed [32:0] d_full;
    logic        [30:0] d_clamped;
    logic signed [31:0] dvar;
    logic signed [32:0] v_sum;
    logic        [30:0] v_next;
    logic signed [31:0] lp_next;

    // Serial arithmetic units.
    hep_smul #(.FRACTION_BITS(FRACTION_BITS)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    hep_ssqrt #(.FRACTION_BITS(FRACTION_BITS)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sq_req),
        .o_rsp   (sq_rsp)
    );

    // Configuration writes, masked to each register's width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drift_rate        <= RST_DRIFT_RATE;
            r_reversion_speed   <= RST_REVERSION_SPEED;
            r_long_run_variance <= RST_LONG_RUN_VARIANCE;
            r_vol_of_vol        <= RST_VOL_OF_VOL;
            r_correlation       <= RST_CORRELATION;
            r_time_step         <= RST_TIME_STEP;
            r_start_log_price   <= RST_START_LOG_PRICE;
            r_start_variance    <= RST_START_VARIANCE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DRIFT_RATE:        r_drift_rate        <= i_cfg_data[31:0];
                REG_REVERSION_SPEED:   r_reversion_speed   <= i_cfg_data[30:0];
                REG_LONG_RUN_VARIANCE: r_long_run_variance <= i_cfg_data[30:0];
                REG_VOL_OF_VOL:        r_vol_of_vol        <= i_cfg_data[30:0];
                REG_CORRELATION:       r_correlation       <= i_cfg_data[25:0];
                REG_TIME_STEP:         r_time_step         <= i_cfg_data[24:0];
                REG_START_LOG_PRICE:   r_start_log_price   <= i_cfg_data[31:0];
                REG_START_VARIANCE:    r_start_variance    <= i_cfg_data[30:0];
                default: begin
                end
            endcase
        end
    end

    // Operand widening and the short add/compare terms.
    always_comb begin
        z1_ext  = {{16{r_z1[15]}}, r_z1};
        z2_ext  = {{16{r_z2[15]}}, r_z2};
        rho_ext = {{6{r_correlation[25]}}, r_correlation};
        dt_ext  = {7'b0, r_time_step};
        drift   = sat33({r_drift_rate[31], r_drift_rate} - $signed({3'b0, r_v[30:1]}));
        rev     = sat33($signed({2'b0, r_long_run_variance}) - $signed({2'b0, r_v}));
        // 1 - rho^2, taken as zero when rho lies beyond one.
        d_full  = (33'sd1 <<< FRACTION_BITS) - $signed({r_t[31], r_t});
        d_clamped = d_full[32] ? 31'd0 : d_full[30:0];
        // Variance update, clamped to the non-negative 31-bit range.
        dvar    = sat33({r_t[31], r_t} + {mul_rsp.value[31], mul_rsp.value});
        v_sum   = $signed({2'b0, r_v}) + $signed({dvar[31], dvar});
        if (v_sum[32]) begin
            v_next = '0;
        end else if (v_sum[31]) begin
            v_next = 31'h7fff_ffff;
        end else begin
            v_next = v_sum[30:0];
        end
        // Log price update: both terms summed and saturated, then the running value.
        lp_next = sat33({r_lp[31], r_lp}
                        + {dvar[31], dvar});
    end

    // Unit selection and operand routing by state.
    always_comb begin
        is_mul_state = r_state inside {S_RHO2, S_DWS, S_M1, S_M2, S_DWV, S_T1, S_T2,
                                       S_A, S_B, S_C, S_E};
        is_sq_state  = r_state inside {S_RS, S_DF, S_SV};
        unit_done    = is_mul_state ? mul_rsp.done : (is_sq_state && sq_rsp.done);

        mul_req.start      = is_mul_state && !r_busy;
        mul_req.a          = '0;
        mul_req.b          = '0;
        mul_req.long_shift = 1'b1;
        sq_req.start       = is_sq_state && !r_busy;
        sq_req.radicand    = '0;

        case (r_state)
            S_RS:   sq_req.radicand = {6'b0, r_time_step};
            S_RHO2: begin mul_req.a = rho_ext; mul_req.b = rho_ext; end
            S_DF:   sq_req.radicand = d_clamped;
            S_DWS:  begin mul_req.a = r_rs;  mul_req.b = z1_ext; mul_req.long_shift = 1'b0; end
            S_M1:   begin mul_req.a = rho_ext; mul_req.b = z1_ext; mul_req.long_shift = 1'b0; end
            S_M2:   begin mul_req.a = r_df;  mul_req.b = z2_ext; mul_req.long_shift = 1'b0; end
            S_DWV:  begin mul_req.a = r_rs;  mul_req.b = r_mix; end
            S_SV:   sq_req.radicand = r_v;
            S_T1:   begin mul_req.a = drift; mul_req.b = dt_ext; end
            S_T2:   begin mul_req.a = r_sv;  mul_req.b = r_dws; end
            S_A:    begin mul_req.a = {1'b0, r_reversion_speed}; mul_req.b = rev; end
            S_B:    begin mul_req.a = r_a;   mul_req.b = dt_ext; end
            S_C:    begin mul_req.a = {1'b0, r_vol_of_vol}; mul_req.b = r_sv; end
            S_E:    begin mul_req.a = r_a;   mul_req.b = r_dwv; end
            default: begin
            end
        endcase
    end

    // Handshakes.
    assign i_item.ready = (r_state == S_IDLE);
    assign accept       = i_item.valid && i_item.ready;
    assign emit_load    = (r_state == S_EMIT) && (!r_out_valid || o_result.ready);

    // Next-state sequence of operations.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = i_item.first_step ? S_RS : S_DWS;
                end
            end
            S_EMIT: begin
                if (emit_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                if (unit_done) begin
                    case (r_state)
                        S_RS:    n_state = S_RHO2;
                        S_RHO2:  n_state = S_DF;
                        S_DF:    n_state = S_DWS;
                        S_DWS:   n_state = S_M1;
                        S_M1:    n_state = S_M2;
                        S_M2:    n_state = S_DWV;
                        S_DWV:   n_state = S_SV;
                        S_SV:    n_state = S_T1;
                        S_T1:    n_state = S_T2;
                        S_T2:    n_state = S_A;
                        S_A:     n_state = S_B;
                        S_B:     n_state = S_C;
                        S_C:     n_state = S_E;
                        S_E:     n_state = r_last ? S_EMIT : S_IDLE;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
        endcase
    end

    // Sequencer control and output register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (mul_req.start || sq_req.start) begin
                r_busy <= 1'b1;
            end else if (unit_done) begin
                r_busy <= 1'b0;
            end
            if (emit_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Path state: reset to zero, loaded at path start, written when the operation that produces it finishes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp <= '0;
            r_v  <= '0;
            r_rs <= '0;
            r_df <= '0;
        end else begin
            if (accept && i_item.first_step) begin
                r_lp <= r_start_log_price;
                r_v  <= r_start_variance;
            end
            if (unit_done) begin
                case (r_state)
                    S_RS:  r_rs <= sq_rsp.value;
                    S_DF:  r_df <= sq_rsp.value;
                    S_T2:  r_lp <= lp_next;
                    S_E:   r_v  <= v_next;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Intermediate results and the captured input word.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_z1   <= i_item.normal_a;
            r_z2   <= i_item.normal_b;
            r_last <= i_item.last_step;
        end
        if (unit_done) begin
            case (r_state)
                S_RHO2: r_t   <= mul_rsp.value;
                S_DWS:  r_dws <= mul_rsp.value;
                S_M1:   r_mix <= mul_rsp.value;
                S_M2:   r_mix <= sat33({r_mix[31], r_mix}
                                       + {mul_rsp.value[31], mul_rsp.value});
                S_DWV:  r_dwv <= mul_rsp.value;
                S_SV:   r_sv  <= sq_rsp.value;
                S_T1:   r_t   <= mul_rsp.value;
                S_A:    r_a   <= mul_rsp.value;
                S_B:    r_t   <= mul_rsp.value;
                S_C:    r_a   <= mul_rsp.value;
                default: begin
                end
            endcase
        end
        if (emit_load) begin
            r_out_lp <= r_lp;
            r_out_v  <= r_v;
        end
    end

    assign o_result.valid              = r_out_valid;
    assign o_result.terminal_log_price = r_out_lp;
    assign o_result.terminal_variance  = r_out_v;

    // The two units are never started in the same cycle.
    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mul_req.start && sq_req.start))
        else $error("multiplier and square root started together");

    // An accepted word always starts the sequencer.
    a_accept_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("accepted word did not start a step");

    // A multiplier result only arrives for an issued multiply.
    a_mul_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_rsp.done |-> (r_busy && is_mul_state))
        else $error("multiplier result without a pending multiply");

    // A waiting result is never overwritten by the next one.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_out_valid && !o_result.ready)
            |=> (r_state == S_EMIT && r_out_valid))
        else $error("pending result overwritten");

    // Loading the output register always presents a result.
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_load |=> r_out_valid)
        else $error("result loaded but not presented");

endmodule

// File: rtl/core/hep_smul.sv
// Bit-serial signed 32x32 multiplier with floor shift and 32-bit saturation.
module hep_smul #(
    parameter int FRACTION_BITS = hep_pkg::DEFAULT_FRACTION_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hep_pkg::t_mul_req  i_req,
    output hep_pkg::t_unit_rsp o_rsp
);
    import hep_pkg::*;

    localparam int OP_W   = WORD_W;
    localparam int PROD_W = 2 * WORD_W;
    localparam int CNT_W  = $clog2(OP_W);

    logic signed [PROD_W-1:0] r_acc;
    logic        [PROD_W-1:0] r_mcand;
    logic        [OP_W-1:0]   r_mplier;
    logic        [CNT_W-1:0]  r_cnt;
    logic                     r_run;
    logic                     r_done;
    logic                     r_long;

    logic        [PROD_W-1:0] addend;
    logic signed [PROD_W-1:0] n_acc;
    logic signed [PROD_W-1:0] shifted;

    // One multiplier bit per cycle; the top bit carries negative weight.
    always_comb begin
        addend = r_mplier[0] ? r_mcand : '0;
        if (r_cnt == CNT_W'(OP_W - 1)) begin
            n_acc = r_acc - $signed(addend);
        end else begin
            n_acc = r_acc + $signed(addend);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run    <= 1'b1;
                r_cnt    <= '0;
                r_acc    <= '0;
                r_mcand  <= {{(PROD_W - OP_W){i_req.a[OP_W-1]}}, i_req.a};
                r_mplier <= i_req.b;
                r_long   <= i_req.long_shift;
            end else if (r_run) begin
                r_acc    <= n_acc;
                r_mcand  <= r_mcand << 1;
                r_mplier <= r_mplier >> 1;
                r_cnt    <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(OP_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Floor shift by the selected fraction, then clamp to 32 bits.
    always_comb begin
        shifted = r_long ? (r_acc >>> FRACTION_BITS) : (r_acc >>> NORMAL_FRACTION);
        o_rsp.done = r_done;
        if ((&shifted[PROD_W-1:OP_W-1]) || !(|shifted[PROD_W-1:OP_W-1])) begin
            o_rsp.value = shifted[OP_W-1:0];
        end else begin
            o_rsp.value = shifted[PROD_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
    end

endmodule

// File: rtl/core/hep_ssqrt.sv
// Digit-serial square root of a Q value: floor(sqrt(x << FRACTION_BITS)), one bit a cycle.
module hep_ssqrt #(
    parameter int FRACTION_BITS = hep_pkg::DEFAULT_FRACTION_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hep_pkg::t_sqrt_req i_req,
    output hep_pkg::t_unit_rsp o_rsp
);
    import hep_pkg::*;

    localparam int IN_W   = 31;
    localparam int RAD_W  = IN_W + FRACTION_BITS;
    localparam int ROOT_W = (RAD_W + 1) / 2;
    localparam int RAD2_W = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 3;
    localparam int CNT_W  = $clog2(ROOT_W);

    logic [RAD2_W-1:0] r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_run;
    logic              r_done;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              fits;

    // Bring down two radicand bits and try the next root bit.
    always_comb begin
        rem_sh = {r_rem[REM_W-3:0], r_rad[RAD2_W-1:RAD2_W-2]};
        trial  = REM_W'({r_root, 2'b01});
        fits   = (rem_sh >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run  <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_root <= '0;
                r_rad  <= RAD2_W'({i_req.radicand, {FRACTION_BITS{1'b0}}});
            end else if (r_run) begin
                r_rad  <= r_rad << 2;
                r_rem  <= fits ? (rem_sh - trial) : rem_sh;
                r_root <= {r_root[ROOT_W-2:0], fits};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ROOT_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = WORD_W'(r_root);

endmodule
